>>> design/assert_macros.svh
// assertion helpers shared by the design files
// each macro expects clk and rst_n in the enclosing module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/gld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gld_pkg
// Shared widths, register map and reset values of the grid line coverage block.
// ----------------------------------------------------------------------------
package gld_pkg;

    localparam int COORD_W = 32;
    localparam int CELL_W  = 31;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    localparam logic [CELL_W-1:0] CELL_MAX   = '1;
    localparam logic [CELL_W-1:0] CELL_RESET = CELL_W'(65536);
    localparam logic [CELL_W-1:0] CELL_EPS   = CELL_W'(1);

    // register index taken from paddr[2]
    localparam logic REG_CELL_SIZE = 1'b0;

endpackage

>>> design/gld_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gld_div
// Pipelined restoring divider, one quotient bit per stage, with a sideband
// field that travels alongside each item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gld_div #(
    parameter int NW = 48,
    parameter int DW = 31,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] numer,
    input  logic [DW-1:0] denom,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [NW-1:0] quot,
    output logic [DW-1:0] rem,
    output logic [SW-1:0] side_out
);

    logic [NW-1:0] vld_reg;
    logic [NW-1:0] nq_reg   [NW];
    logic [DW-1:0] rem_reg  [NW];
    logic [DW-1:0] den_reg  [NW];
    logic [SW-1:0] side_reg [NW];

    logic [NW-1:0] nq_src   [NW];
    logic [DW-1:0] rem_src  [NW];
    logic [DW-1:0] den_src  [NW];
    logic [SW-1:0] side_src [NW];
    logic [DW:0]   trial    [NW];
    logic          ge       [NW];
    logic [NW-1:0] nq_next  [NW];
    logic [DW-1:0] rem_next [NW];

    always_comb
    begin
        nq_src[0]   = numer;
        rem_src[0]  = '0;
        den_src[0]  = denom;
        side_src[0] = side_in;
        for (int s = 1; s < NW; s++)
        begin
            nq_src[s]   = nq_reg[s-1];
            rem_src[s]  = rem_reg[s-1];
            den_src[s]  = den_reg[s-1];
            side_src[s] = side_reg[s-1];
        end
        for (int s = 0; s < NW; s++)
        begin
            trial[s]    = {rem_src[s], nq_src[s][NW-1]};
            ge[s]       = trial[s] >= {1'b0, den_src[s]};
            rem_next[s] = ge[s] ? DW'(trial[s] - {1'b0, den_src[s]}) : trial[s][DW-1:0];
            nq_next[s]  = {nq_src[s][NW-2:0], ge[s]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NW-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NW; s++)
            begin
                nq_reg[s]   <= nq_next[s];
                rem_reg[s]  <= rem_next[s];
                den_reg[s]  <= den_src[s];
                side_reg[s] <= side_src[s];
            end
        end
    end

    assign out_valid = vld_reg[NW-1];
    assign quot      = nq_reg[NW-1];
    assign rem       = rem_reg[NW-1];
    assign side_out  = side_reg[NW-1];

    `CHK_IMPLY(a_rem_below_den, out_valid && (den_reg[NW-1] != '0),
        rem < den_reg[NW-1], "divider remainder not below divisor")

endmodule

>>> design/gld_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gld_axis
// Per-axis stage between the dividers: floor correction and saturation of the
// cell coordinate, distance to the nearest boundary, clamped footprint.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gld_axis #(
    parameter int F = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic                            sign,
    input  logic [gld_pkg::COORD_W+F-1:0]   qc,
    input  logic [gld_pkg::CELL_W-1:0]      rc,
    input  logic [gld_pkg::COORD_W+F-1:0]   qd,
    output logic                            out_valid,
    output logic [2*F-1:0]                  numer,
    output logic [gld_pkg::CELL_W-1:0]      denom
);

    localparam int NW = gld_pkg::COORD_W + F;
    localparam logic [F-1:0] HALF = F'(1) << (F - 1);

    logic [NW:0]                   qn;
    logic                          sat_p;
    logic                          sat_n;
    logic                          sat_d;
    logic [F-1:0]                  lo;
    logic [F-1:0]                  fr;
    logic [F-1:0]                  bdist;
    logic [gld_pkg::CELL_W-1:0]    dqv;
    logic                          valid_reg;
    logic [2*F-1:0]                numer_reg;
    logic [gld_pkg::CELL_W-1:0]    denom_reg;
    logic [2*F-1:0]                numer_next;
    logic [gld_pkg::CELL_W-1:0]    denom_next;

    always_comb
    begin
        qn    = {1'b0, qc} + (NW+1)'(|rc);
        sat_p = |qc[NW-1:31];
        sat_n = (|qn[NW:32]) || (qn[31] && (|qn[30:0]));
        if (sign)
        begin
            lo = sat_n ? '0 : F'((~qn[F-1:0]) + F'(1));
        end
        else
        begin
            lo = sat_p ? '1 : qc[F-1:0];
        end
        fr    = lo - HALF;
        bdist = (fr >= HALF) ? (fr - HALF) : (HALF - fr);
        numer_next = {bdist, F'(0)};

        sat_d = |qd[NW-1:31];
        dqv   = sat_d ? gld_pkg::CELL_MAX : qd[gld_pkg::CELL_W-1:0];
        denom_next = (dqv == '0) ? gld_pkg::CELL_EPS : dqv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            numer_reg <= numer_next;
            denom_reg <= denom_next;
        end
    end

    assign out_valid = valid_reg;
    assign numer     = numer_reg;
    assign denom     = denom_reg;

    `CHK_IMPLY(a_dist_half, valid_reg, numer_reg[2*F-1:F] <= HALF,
        "boundary distance above half a cell")
    `CHK_IMPLY(a_denom_nz, valid_reg, denom_reg != '0, "footprint divisor is zero")

endmodule

>>> design/grid_line_coverage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_line_coverage
// Anti-aliased grid line coverage for one ground-plane pixel per item.
//
// Input channel (in_valid / in_stall) carries world_x, world_z, deriv_x and
// deriv_z in signed fixed point; output channel (out_valid / out_stall)
// returns coverage, unsigned, 2^FRAC_BITS meaning full.
// cell_size is written over the APB port at address 0; the user must write it
// only while the block is idle, which the block itself does not enforce.
// The pipeline is a 32+FRAC_BITS stage divider by the cell size, one boundary
// stage, a 2*FRAC_BITS stage divider by the footprint, one output register.
// One item is taken per cycle unless the output stall freezes the pipeline;
// every divider stage is registered, so items can follow back to back.
// Reset empties the pipeline and sets cell_size to 1.0.
// While the receiver stalls a held result, the whole pipeline freezes and
// in_stall is raised in the same cycle; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module grid_line_coverage #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gld_pkg::ADDR_W-1:0]    paddr,
    input  logic [gld_pkg::DATA_W-1:0]    pwdata,
    output logic [gld_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [31:0]            world_x,
    input  logic signed [31:0]            world_z,
    input  logic signed [31:0]            deriv_x,
    input  logic signed [31:0]            deriv_z,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [FRAC_BITS:0]            coverage
);

    localparam int F  = FRAC_BITS;
    localparam int NW = gld_pkg::COORD_W + F;
    localparam int GW = 2 * F;
    localparam logic [F:0] ONE = (F+1)'(1) << F;
    localparam logic [gld_pkg::CELL_W-1:0] CELL_ONE = {{(gld_pkg::CELL_W-1){1'b0}}, 1'b1} << F;

    logic                          en;
    logic [gld_pkg::CELL_W-1:0]    cell_reg;
    logic                          cfg_wr;

    logic [31:0]                   wpos   [2];
    logic [31:0]                   wder   [2];
    logic [31:0]                   pmag   [2];
    logic [31:0]                   dmag   [2];
    logic                          c_vld  [2];
    logic                          d_vld  [2];
    logic                          c_sgn  [2];
    logic [NW-1:0]                 c_q    [2];
    logic [gld_pkg::CELL_W-1:0]    c_r    [2];
    logic [NW-1:0]                 d_q    [2];
    logic                          a_vld  [2];
    logic [GW-1:0]                 a_num  [2];
    logic [gld_pkg::CELL_W-1:0]    a_den  [2];
    logic                          g_vld  [2];
    logic [GW-1:0]                 g_q    [2];
    logic [F:0]                    g_sat  [2];

    logic [F:0]                    gmin;
    logic [F:0]                    coverage_next;
    logic                          out_valid_reg;
    logic [F:0]                    coverage_reg;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == gld_pkg::REG_CELL_SIZE);
    assign prdata = (paddr[2] == gld_pkg::REG_CELL_SIZE) ? {1'b0, cell_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= CELL_ONE;
        end
        else if (cfg_wr)
        begin
            cell_reg <= pwdata[gld_pkg::CELL_W-1:0];
        end
    end

    // pipeline advance
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    assign wpos[0] = world_x;
    assign wpos[1] = world_z;
    assign wder[0] = deriv_x;
    assign wder[1] = deriv_z;

    for (genvar k = 0; k < 2; k++)
    begin : g_axis
        assign pmag[k] = wpos[k][31] ? (32'(0) - wpos[k]) : wpos[k];
        assign dmag[k] = wder[k][31] ? (32'(0) - wder[k]) : wder[k];

        gld_div #(.NW(NW), .DW(gld_pkg::CELL_W), .SW(1)) u_cdiv (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (in_valid),
            .numer     ({pmag[k], F'(0)}),
            .denom     (cell_reg),
            .side_in   (wpos[k][31]),
            .out_valid (c_vld[k]),
            .quot      (c_q[k]),
            .rem       (c_r[k]),
            .side_out  (c_sgn[k])
        );

        gld_div #(.NW(NW), .DW(gld_pkg::CELL_W), .SW(1)) u_ddiv (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (in_valid),
            .numer     ({dmag[k], F'(0)}),
            .denom     (cell_reg),
            .side_in   (1'b0),
            .out_valid (d_vld[k]),
            .quot      (d_q[k]),
            .rem       (),
            .side_out  ()
        );

        gld_axis #(.F(F)) u_axis (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (c_vld[k] && d_vld[k]),
            .sign      (c_sgn[k]),
            .qc        (c_q[k]),
            .rc        (c_r[k]),
            .qd        (d_q[k]),
            .out_valid (a_vld[k]),
            .numer     (a_num[k]),
            .denom     (a_den[k])
        );

        gld_div #(.NW(GW), .DW(gld_pkg::CELL_W), .SW(1)) u_gdiv (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (a_vld[k]),
            .numer     (a_num[k]),
            .denom     (a_den[k]),
            .side_in   (1'b0),
            .out_valid (g_vld[k]),
            .quot      (g_q[k]),
            .rem       (),
            .side_out  ()
        );

        assign g_sat[k] = ((|g_q[k][GW-1:F+1]) || (g_q[k][F] && (|g_q[k][F-1:0])))
                          ? ONE : g_q[k][F:0];
    end

    always_comb
    begin
        gmin = (g_sat[0] < g_sat[1]) ? g_sat[0] : g_sat[1];
        coverage_next = (cell_reg <= gld_pkg::CELL_EPS) ? '0 : (ONE - gmin);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= g_vld[0] && g_vld[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            coverage_reg <= coverage_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign coverage  = coverage_reg;

    `CHK_IMPLY(a_cov_range, out_valid_reg, coverage_reg <= ONE, "coverage above full")
    `CHK_NEXT(a_cfg_write, cfg_wr, cell_reg == $past(pwdata[gld_pkg::CELL_W-1:0]),
        "cell size write lost")

endmodule
